[hw/rtl/utd_pkg.sv]
// Shared types and constants for the UTF-8 to UTF-16 decoder.
`timescale 1ns / 1ps

package utd_pkg;

    localparam int BYTE_W        = 8;
    localparam int UNIT_W        = 16;
    localparam int ACC_W         = 32;
    localparam int REM_W         = 3;
    localparam int COUNT_OUT_W   = 32;
    localparam int COUNT_WIDTH_DEF = 32;

    localparam logic [UNIT_W-1:0] SURR_HIGH_BASE = 16'hD800;
    localparam logic [UNIT_W-1:0] SURR_LOW_BASE  = 16'hDC00;

    // One result item as it sits in the output queue.
    typedef struct packed {
        logic [UNIT_W-1:0]      code_unit;
        logic                   unit_valid;
        logic                   run_last;
        logic                   string_done;
        logic                   status;
        logic [COUNT_OUT_W-1:0] unit_count;
    } result_t;

endpackage

[hw/rtl/utd_ifs.sv]
// Valid/ready channel interfaces for the byte input and the code unit output.
`timescale 1ns / 1ps

interface utd_byte_if;
    logic                       valid;
    logic                       ready;
    logic [utd_pkg::BYTE_W-1:0] data_byte;
    logic                       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface utd_unit_if;
    logic                            valid;
    logic                            ready;
    logic [utd_pkg::UNIT_W-1:0]      code_unit;
    logic                            unit_valid;
    logic                            run_last;
    logic                            string_done;
    logic                            status;
    logic [utd_pkg::COUNT_OUT_W-1:0] unit_count;

    modport source (output valid, output code_unit, output unit_valid, output run_last,
                    output string_done, output status, output unit_count, input ready);
    modport sink   (input valid, input code_unit, input unit_valid, input run_last,
                    input string_done, input status, input unit_count, output ready);
endinterface

[hw/rtl/utf8_to_utf16_decoder.sv]
// UTF-8 to UTF-16 decoder: top level with sequence state and a two-entry result queue.
`timescale 1ns / 1ps

// The decoder takes one UTF-8 byte per item and returns UTF-16 code units. Each
// accepted byte is decoded in the cycle it is accepted: the sequence state
// (accumulated value, continuation bytes still expected, unit count, skip flag)
// is updated at that edge and the results it causes are written into a
// two-entry output queue, so the first result shows on the output in the next
// cycle. A byte that gives no unit and does not end the string gives no result.
// With the output side ready, the block takes one byte every cycle. A byte
// that completes a supplementary-plane character gives a surrogate pair, high
// half first; the pair leaves the queue one half at a time, and the next byte
// is held off while the low half drains. The input is ready whenever the
// queue will be empty after this cycle's output transfer. The end of a string
// (a zero byte, last_byte, or an error) is flagged with string_done and status
// on the last result of that byte; a result with unit_valid low carries it
// when the byte made no unit. After an early end, bytes are swallowed up to and
// including the next byte marked last_byte. unit_count saturates at
// 2**COUNT_WIDTH - 1, or at the 32-bit maximum for widths of 32 and more.
module utf8_to_utf16_decoder #(
    parameter int COUNT_WIDTH = utd_pkg::COUNT_WIDTH_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    utd_byte_if.sink          byte_in,
    utd_unit_if.source        unit_out
);

    localparam int CW = (COUNT_WIDTH >= utd_pkg::COUNT_OUT_W) ? utd_pkg::COUNT_OUT_W
                                                              : COUNT_WIDTH;

    // Sequence state.
    logic [utd_pkg::ACC_W-1:0] acc_reg, acc_next;
    logic [utd_pkg::REM_W-1:0] rem_reg, rem_next;
    logic [CW-1:0]             cnt_reg, cnt_next;
    logic                      skip_reg, skip_next;

    // Output queue: entry 0 is the head.
    utd_pkg::result_t q0_reg, q1_reg;
    logic [1:0]       qcnt_reg, qcnt_next;

    logic in_fire, out_fire;

    // Decode of the current byte.
    logic [utd_pkg::BYTE_W-1:0] in_byte;
    logic                       in_last;
    logic                       emit_en, direct_en, lead_err, is_lead, end_str;
    logic [utd_pkg::ACC_W-1:0]  emit_val;
    logic                       val_small, val_pair;
    logic [3:0]                 w_top;
    logic [utd_pkg::UNIT_W-1:0] surr_hi, surr_lo;
    logic                       err, ends_now;
    logic [CW-1:0]              cnt_p1, cnt_p2;
    logic [1:0]                 n_units, n_res;
    utd_pkg::result_t           r0, r1;

    assign in_byte = byte_in.data_byte;
    assign in_last = byte_in.last_byte;

    assign out_fire = unit_out.valid && unit_out.ready;
    assign byte_in.ready = (qcnt_reg == 2'd0) || ((qcnt_reg == 2'd1) && unit_out.ready);
    assign in_fire = byte_in.valid && byte_in.ready;

    assign cnt_p1 = (cnt_reg == {CW{1'b1}}) ? cnt_reg : cnt_reg + 1'b1;
    assign cnt_p2 = (cnt_p1 == {CW{1'b1}}) ? cnt_p1 : cnt_p1 + 1'b1;

    // Byte decode and sequence state update.
    always_comb
    begin
        acc_next  = acc_reg;
        rem_next  = rem_reg;
        emit_en   = 1'b0;
        emit_val  = acc_reg;
        direct_en = 1'b0;
        lead_err  = 1'b0;
        is_lead   = 1'b0;
        end_str   = 1'b0;
        if (skip_reg)
        begin
            // Nothing decoded while swallowing the rest of an ended string.
        end
        else if (rem_reg != '0)
        begin
            if (in_byte[7:6] == 2'b10)
            begin
                acc_next = {acc_reg[utd_pkg::ACC_W-7:0], in_byte[5:0]};
                rem_next = rem_reg - 1'b1;
                if ((rem_next == '0) || in_last)
                begin
                    rem_next = '0;
                    emit_en  = 1'b1;
                    emit_val = acc_next;
                end
            end
            else
            begin
                // Interrupted sequence: the partial value goes out, the byte is dropped.
                rem_next = '0;
                emit_en  = 1'b1;
                emit_val = acc_reg;
                end_str  = (in_byte == '0);
            end
        end
        else
        begin
            case (in_byte) inside
                8'h00:          end_str   = 1'b1;
                [8'h01:8'h7F]:  direct_en = 1'b1;
                [8'h80:8'hBF]:  lead_err  = 1'b1;
                [8'hC0:8'hDF]:
                begin
                    is_lead  = 1'b1;
                    acc_next = utd_pkg::ACC_W'(in_byte[4:0]);
                    rem_next = 3'd1;
                end
                [8'hE0:8'hEF]:
                begin
                    is_lead  = 1'b1;
                    acc_next = utd_pkg::ACC_W'(in_byte[3:0]);
                    rem_next = 3'd2;
                end
                [8'hF0:8'hF7]:
                begin
                    is_lead  = 1'b1;
                    acc_next = utd_pkg::ACC_W'(in_byte[2:0]);
                    rem_next = 3'd3;
                end
                [8'hF8:8'hFB]:
                begin
                    is_lead  = 1'b1;
                    acc_next = utd_pkg::ACC_W'(in_byte[1:0]);
                    rem_next = 3'd4;
                end
                default:
                begin
                    is_lead  = 1'b1;
                    acc_next = utd_pkg::ACC_W'(in_byte[1:0]);
                    rem_next = 3'd5;
                end
            endcase
            if (is_lead && in_last)
            begin
                // Truncated right at the lead byte.
                rem_next = '0;
                emit_en  = 1'b1;
                emit_val = acc_next;
            end
        end
    end

    // Value classification and surrogate split.
    assign val_small = (emit_val[31:16] == '0);
    assign val_pair  = (emit_val[31:21] == '0) && (emit_val[20:16] != '0)
                       && (emit_val[20:16] <= 5'h10);
    assign w_top     = 4'(emit_val[20:16] - 5'd1);
    assign surr_hi   = utd_pkg::SURR_HIGH_BASE | utd_pkg::UNIT_W'({w_top, emit_val[15:10]});
    assign surr_lo   = utd_pkg::SURR_LOW_BASE  | utd_pkg::UNIT_W'(emit_val[9:0]);

    assign err      = lead_err || (emit_en && !val_small && !val_pair);
    assign ends_now = !skip_reg && (end_str || in_last || err);

    // Result assembly and end-of-string handling.
    always_comb
    begin
        r0 = '0;
        r1 = '0;
        n_units = 2'd0;
        r0.unit_count = utd_pkg::COUNT_OUT_W'(cnt_p1);
        r1.unit_count = utd_pkg::COUNT_OUT_W'(cnt_p2);
        if (direct_en)
        begin
            r0.code_unit  = utd_pkg::UNIT_W'(in_byte);
            r0.unit_valid = 1'b1;
            n_units       = 2'd1;
        end
        else if (emit_en && val_small)
        begin
            r0.code_unit  = emit_val[15:0];
            r0.unit_valid = 1'b1;
            n_units       = 2'd1;
        end
        else if (emit_en && val_pair)
        begin
            r0.code_unit  = surr_hi;
            r0.unit_valid = 1'b1;
            r1.code_unit  = surr_lo;
            r1.unit_valid = 1'b1;
            n_units       = 2'd2;
        end

        n_res = n_units;
        if (ends_now && (n_units == 2'd0))
        begin
            r0.unit_count = utd_pkg::COUNT_OUT_W'(cnt_reg);
            n_res = 2'd1;
        end

        case (n_res)
            2'd1:
            begin
                r0.run_last    = 1'b1;
                r0.string_done = ends_now;
                r0.status      = ends_now && err;
            end
            2'd2:
            begin
                r1.run_last    = 1'b1;
                r1.string_done = ends_now;
                r1.status      = ends_now && err;
            end
            default:
            begin
                r0.run_last = 1'b0;
            end
        endcase

        skip_next = skip_reg;
        case (n_units)
            2'd1:    cnt_next = cnt_p1;
            2'd2:    cnt_next = cnt_p2;
            default: cnt_next = cnt_reg;
        endcase
        if (skip_reg && in_last)
        begin
            skip_next = 1'b0;
        end
        if (ends_now)
        begin
            cnt_next  = '0;
            skip_next = !in_last;
        end
    end

    // Queue occupancy: a byte is only taken when the queue drains this cycle.
    always_comb
    begin
        if (in_fire)
        begin
            qcnt_next = n_res;
        end
        else if (out_fire)
        begin
            qcnt_next = qcnt_reg - 1'b1;
        end
        else
        begin
            qcnt_next = qcnt_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg  <= '0;
            rem_reg  <= '0;
            cnt_reg  <= '0;
            skip_reg <= 1'b0;
            qcnt_reg <= 2'd0;
        end
        else
        begin
            qcnt_reg <= qcnt_next;
            if (in_fire)
            begin
                acc_reg  <= ends_now ? '0 : acc_next;
                rem_reg  <= ends_now ? '0 : rem_next;
                cnt_reg  <= cnt_next;
                skip_reg <= skip_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            q0_reg <= r0;
            q1_reg <= r1;
        end
        else if (out_fire)
        begin
            q0_reg <= q1_reg;
        end
    end

    assign unit_out.valid       = (qcnt_reg != 2'd0);
    assign unit_out.code_unit   = q0_reg.code_unit;
    assign unit_out.unit_valid  = q0_reg.unit_valid;
    assign unit_out.run_last    = q0_reg.run_last;
    assign unit_out.string_done = q0_reg.string_done;
    assign unit_out.status      = q0_reg.status;
    assign unit_out.unit_count  = q0_reg.unit_count;

endmodule

[tb/utf8_to_utf16_decoder_checker.sv]
// Checker for the UTF-8 to UTF-16 decoder: tracks accepted bytes, predicts code units, compares.
`timescale 1ns / 1ps

module utf8_to_utf16_decoder_checker #(
    parameter int COUNT_WIDTH = utd_pkg::COUNT_WIDTH_DEF
) (
    input  logic clk,
    input  logic rst_n,
    utd_byte_if  byte_ch,
    utd_unit_if  unit_ch,
    output int   fail_count,
    output int   pending,
    output int   units_seen,
    output int   pairs_seen,
    output int   strings_seen,
    output int   malformed_seen
);

    localparam logic [31:0] UNIT_LIMIT = (COUNT_WIDTH >= 32) ? 32'hFFFF_FFFF :
                                         32'((64'd1 << COUNT_WIDTH) - 64'd1);

    // Decoder state as the hardware should hold it.
    logic [31:0] seq_value;
    logic [2:0]  cont_left;
    logic [31:0] string_units;
    logic        skip_rest;

    // Results of the byte being decoded, at most a surrogate pair.
    utd_pkg::result_t step_res [2];
    int               step_n;
    logic             step_bad;

    utd_pkg::result_t expected_units [$];
    utd_pkg::result_t got;
    utd_pkg::result_t want;

    function automatic void add_unit(input logic [15:0] unit);
        if (string_units < UNIT_LIMIT)
            string_units = string_units + 32'd1;
        step_res[step_n] = '{code_unit: unit, unit_valid: 1'b1, run_last: 1'b0,
                             string_done: 1'b0, status: 1'b0, unit_count: string_units};
        step_n++;
    endfunction

    // Values past the basic plane split into a surrogate pair; past U+10FFFF they are an error.
    function automatic void add_value(input logic [31:0] value);
        logic [31:0] offset;
        if (value < 32'h1_0000) begin
            add_unit(value[15:0]);
        end
        else begin
            offset = value - 32'h1_0000;
            if (offset >= 32'h10_0000) begin
                step_bad = 1'b1;
            end
            else begin
                add_unit(utd_pkg::SURR_HIGH_BASE + 16'(offset >> 10));
                add_unit(utd_pkg::SURR_LOW_BASE + 16'(offset & 32'h3FF));
            end
        end
    endfunction

    function automatic void decode_byte(input logic [7:0] b, input logic lst);
        logic       ended;
        logic [2:0] adds;
        logic [7:0] base;
        step_n   = 0;
        step_bad = 1'b0;
        ended    = 1'b0;
        if (skip_rest) begin
            if (lst)
                skip_rest = 1'b0;
            return;
        end
        if (cont_left != 0) begin
            if (b >= 8'h80 && b < 8'hC0) begin
                seq_value = (seq_value << 6) | {26'd0, b[5:0]};
                cont_left = cont_left - 3'd1;
                if (cont_left == 0 || lst) begin
                    cont_left = 3'd0;
                    add_value(seq_value);
                end
            end
            else begin
                // A non-continuation byte flushes the partial value and is dropped.
                cont_left = 3'd0;
                add_value(seq_value);
                if (b == 8'h00)
                    ended = 1'b1;
            end
        end
        else if (b == 8'h00) begin
            ended = 1'b1;
        end
        else if (b < 8'h80) begin
            add_unit({8'h00, b});
        end
        else if (b < 8'hC0) begin
            step_bad = 1'b1;
        end
        else begin
            if (b < 8'hE0) begin
                adds = 3'd1;
                base = 8'hC0;
            end
            else if (b < 8'hF0) begin
                adds = 3'd2;
                base = 8'hE0;
            end
            else if (b < 8'hF8) begin
                adds = 3'd3;
                base = 8'hF0;
            end
            else if (b < 8'hFC) begin
                adds = 3'd4;
                base = 8'hF8;
            end
            else begin
                adds = 3'd5;
                base = 8'hFC;
            end
            seq_value = {24'd0, b - base};
            cont_left = adds;
            if (lst) begin
                cont_left = 3'd0;
                add_value(seq_value);
            end
        end
        if (lst || step_bad)
            ended = 1'b1;
        if (ended) begin
            if (step_n == 0) begin
                step_res[0] = '{code_unit: 16'h0000, unit_valid: 1'b0, run_last: 1'b0,
                                string_done: 1'b0, status: 1'b0, unit_count: string_units};
                step_n = 1;
            end
            step_res[step_n-1].string_done = 1'b1;
            step_res[step_n-1].status      = step_bad;
            seq_value    = '0;
            cont_left    = '0;
            string_units = '0;
            skip_rest    = !lst;
        end
        if (step_n > 0)
            step_res[step_n-1].run_last = 1'b1;
        for (int i = 0; i < step_n; i++)
            expected_units.push_back(step_res[i]);
    endfunction

    function automatic bit field_ok(input string name, input logic [31:0] exp_val,
                                    input logic [31:0] act_val);
        if (act_val === exp_val)
            return 1'b1;
        $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, name, exp_val,
                 act_val);
        return 1'b0;
    endfunction

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            seq_value      = '0;
            cont_left      = '0;
            string_units   = '0;
            skip_rest      = 1'b0;
            expected_units.delete();
            fail_count     = 0;
            pending        = 0;
            units_seen     = 0;
            pairs_seen     = 0;
            strings_seen   = 0;
            malformed_seen = 0;
        end
        else begin
            if (byte_ch.valid && byte_ch.ready)
                decode_byte(byte_ch.data_byte, byte_ch.last_byte);
            if (unit_ch.valid && unit_ch.ready) begin
                got = '{code_unit: unit_ch.code_unit, unit_valid: unit_ch.unit_valid,
                        run_last: unit_ch.run_last, string_done: unit_ch.string_done,
                        status: unit_ch.status, unit_count: unit_ch.unit_count};
                if (expected_units.size() == 0) begin
                    $display("%0t: unexpected result, expected none, got %p", $time, got);
                    fail_count++;
                end
                else begin
                    want = expected_units.pop_front();
                    if (!(field_ok("code_unit", 32'(want.code_unit), 32'(got.code_unit)) &
                          field_ok("unit_valid", 32'(want.unit_valid), 32'(got.unit_valid)) &
                          field_ok("run_last", 32'(want.run_last), 32'(got.run_last)) &
                          field_ok("string_done", 32'(want.string_done),
                                   32'(got.string_done)) &
                          field_ok("status", 32'(want.status), 32'(got.status)) &
                          field_ok("unit_count", want.unit_count, got.unit_count)))
                        fail_count++;
                end
                if (got.unit_valid === 1'b1) begin
                    units_seen++;
                    if (got.code_unit[15:10] == 6'b110110)
                        pairs_seen++;
                end
                if (got.string_done === 1'b1) begin
                    strings_seen++;
                    if (got.status === 1'b1)
                        malformed_seen++;
                end
            end
            pending = expected_units.size();
        end
    end

endmodule

[tb/utf8_to_utf16_decoder_test.sv]
// Top of the decoder testbench: clock, reset, byte stimulus, output pacing and verdict.
`timescale 1ns / 1ps

// The byte stream is driven on one valid/ready channel and the code units are taken
// from the other. A checker beside the block predicts every result from the accepted
// bytes and compares it as it leaves; this module only decides what to send, when to
// stall, and what the verdict is.
module utf8_to_utf16_decoder_test;

    // Kinds of character the random part builds a string from.
    typedef enum int {
        CH_ASCII,
        CH_MULTI,
        CH_CUT,
        CH_STRAY,
        CH_ZERO,
        CH_NOISE
    } char_kind_e;

    // Bit 8 of a directed entry marks the byte as the last one of its string.
    localparam logic [8:0] LAST = 9'h100;

    // The directed part walks through the notable cases in seven strings: one with
    // ASCII, a two-byte and a four-byte character and the highest legal code point,
    // then a value just past U+10FFFF, a stray continuation followed by a swallowed
    // byte, one string with a sequence cut short by ASCII and another cut short by a
    // zero byte (which also ends the string early), a sequence truncated by the last
    // byte, a six-byte form that overflows, and an empty string.
    localparam logic [8:0] DIRECTED [31] = '{
        9'h041, 9'h0C3, 9'h0A9, 9'h0F0, 9'h09F, 9'h098, 9'h080,
        9'h0F4, 9'h08F, 9'h0BF, LAST | 9'h0BF,
        9'h0F4, 9'h090, 9'h080, LAST | 9'h080,
        9'h080, LAST | 9'h000,
        9'h0C3, 9'h041, 9'h0E2, 9'h000, LAST | 9'h042,
        9'h0E2, LAST | 9'h082,
        9'h0FF, 9'h0BF, 9'h0BF, 9'h0BF, 9'h0BF, LAST | 9'h0BF,
        LAST | 9'h000
    };

    logic clk = 1'b0;
    logic rst_n;

    int   src_idle  = 38;
    int   sink_idle = 58;
    int   bytes_sent;

    int   fail_count;
    int   pending;
    int   units_seen;
    int   pairs_seen;
    int   strings_seen;
    int   malformed_seen;

    utd_byte_if byte_ch ();
    utd_unit_if unit_ch ();

    utf8_to_utf16_decoder u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .byte_in  (byte_ch),
        .unit_out (unit_ch)
    );

    utf8_to_utf16_decoder_checker u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .byte_ch        (byte_ch),
        .unit_ch        (unit_ch),
        .fail_count     (fail_count),
        .pending        (pending),
        .units_seen     (units_seen),
        .pairs_seen     (pairs_seen),
        .strings_seen   (strings_seen),
        .malformed_seen (malformed_seen)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // The receiver stalls at random, at the rate of the current phase.
    always @(posedge clk)
    begin
        unit_ch.ready <= ($urandom_range(99) >= sink_idle);
    end

    // Offers one item and returns at the edge where it was taken. Valid is left high,
    // so the next call either keeps it up for a new byte or drops it for a gap.
    task automatic send_byte(input logic [7:0] b, input logic lst);
        while ($urandom_range(99) < src_idle)
        begin
            byte_ch.valid <= 1'b0;
            @(posedge clk);
        end
        byte_ch.valid     <= 1'b1;
        byte_ch.data_byte <= b;
        byte_ch.last_byte <= lst;
        @(posedge clk);
        while (!byte_ch.ready)
            @(posedge clk);
        bytes_sent++;
    endtask

    // Holds the sender back until every predicted result has left the block. The
    // count is read at the falling edge, well clear of the checker's update.
    task automatic wait_for_results();
        int guard;
        guard = 0;
        byte_ch.valid <= 1'b0;
        @(negedge clk);
        while (pending != 0 && guard < 20000)
        begin
            @(negedge clk);
            guard++;
        end
        @(posedge clk);
    endtask

    // One random string. Most characters are well-formed with random payload so that
    // long sequences and surrogate pairs are reached; the rest break the sequence in
    // the ways the decoder has to recover from. The final byte carries last_byte, so
    // a cut sequence at the end becomes a truncation, and an early end leaves the
    // remaining bytes to be swallowed.
    task automatic send_string();
        logic [7:0] text [$];
        char_kind_e kind;
        int         roll;
        int         conts;
        int         chars;
        logic [7:0] lead;
        chars = $urandom_range(1, 8);
        repeat (chars)
        begin
            roll = $urandom_range(99);
            if (roll < 30)
                kind = CH_ASCII;
            else if (roll < 78)
                kind = CH_MULTI;
            else if (roll < 85)
                kind = CH_CUT;
            else if (roll < 89)
                kind = CH_STRAY;
            else if (roll < 92)
                kind = CH_ZERO;
            else
                kind = CH_NOISE;
            case (kind)
                CH_ASCII:
                    text.push_back(8'($urandom_range(1, 127)));
                CH_MULTI, CH_CUT:
                begin
                    roll = $urandom_range(99);
                    conts = (roll < 30) ? 1 : (roll < 60) ? 2 : (roll < 88) ? 3 :
                            (roll < 94) ? 4 : 5;
                    case (conts)
                        1: lead = 8'hC0 | 8'($urandom_range(31));
                        2: lead = 8'hE0 | 8'($urandom_range(15));
                        3: lead = 8'hF0 | 8'($urandom_range(4));
                        4: lead = 8'hF8 | 8'($urandom_range(3));
                        default: lead = 8'hFC | 8'($urandom_range(3));
                    endcase
                    // A cut sequence stops short and is interrupted by whatever follows.
                    if (kind == CH_CUT)
                        conts = $urandom_range(conts - 1);
                    text.push_back(lead);
                    repeat (conts)
                        text.push_back(8'h80 | 8'($urandom_range(63)));
                end
                CH_STRAY:
                    text.push_back(8'h80 | 8'($urandom_range(63)));
                CH_ZERO:
                    text.push_back(8'h00);
                default:
                    text.push_back(8'($urandom_range(255)));
            endcase
        end
        foreach (text[i])
            send_byte(text[i], i == text.size() - 1);
    endtask

    initial
    begin
        #5_000_000;
        $display("Timeout: the decoder stopped making progress");
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial
    begin
        rst_n             <= 1'b0;
        byte_ch.valid     <= 1'b0;
        byte_ch.data_byte <= 8'h00;
        byte_ch.last_byte <= 1'b0;
        bytes_sent = 0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < $size(DIRECTED); i++)
            send_byte(DIRECTED[i][7:0], DIRECTED[i][8]);

        // Sender sparse against a slow receiver.
        while (bytes_sent < 700)
            send_string();
        wait_for_results();

        // Sender idling more often, receiver stalling less often.
        src_idle  = 58;
        sink_idle = 38;
        while (bytes_sent < 1400)
            send_string();
        wait_for_results();

        // Full rate on both sides.
        src_idle  = 0;
        sink_idle = 0;
        while (bytes_sent < 2100)
            send_string();
        wait_for_results();

        // Let any stray late results surface before the verdict.
        repeat (10) @(posedge clk);

        if (pending != 0)
            $display("%0d expected results never arrived", pending);
        $display("Sent %0d bytes over three pacing phases; checked %0d code units, %0d pairs.",
                 bytes_sent, units_seen, pairs_seen);
        $display("Closed %0d strings, %0d of them as malformed.", strings_seen,
                 malformed_seen);
        if (fail_count == 0 && pending == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

[files.f]
hw/rtl/utd_pkg.sv
hw/rtl/utd_ifs.sv
hw/rtl/utf8_to_utf16_decoder.sv
tb/utf8_to_utf16_decoder_checker.sv
tb/utf8_to_utf16_decoder_test.sv
